// File: rtl/core/assert_macros.svh
// Assertion macros for the sort-order RTL.
// Each macro assumes a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define VFK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define VFK_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define VFK_ASSERT(lbl, prop, msg)
`define VFK_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/core/vfkso_pkg.sv
// Package for the valid-first key sort order unit.
// Holds default sizes, field widths, the controller state type and the command/status structs.
`default_nettype none

package vfkso_pkg;

  // Default configuration.
  localparam int ENTRIES_DEF  = 32;
  localparam int KEY_BITS_DEF = 8;

  // Fixed field widths of the ports.
  localparam int IN_KEY_W  = 8;
  localparam int OUT_IDX_W = 5;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_PRIME,
    ST_RUN,
    ST_TAIL,
    ST_EMIT_RD,
    ST_EMIT_WR
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;     // write the transferred entry at the load position
    logic pass_start;  // first pass: set the pass limit and read slot zero
    logic prime;       // take slot zero as the carried record
    logic run;         // one compare-and-write step of a pass
    logic tail;        // write the carried record at the pass limit
    logic emit_rd;     // read the slot at the emit position
    logic emit_wr;     // load the output register from the read data
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_last;     // load/emit position is the last slot
    logic last_cmp;     // current step is the last compare of the pass
    logic more_passes;  // a swap happened and the next pass still has work
    logic out_free;     // output register can take a new transfer
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/valid_first_key_sort_order_unit.sv
// Top level of the valid-first key sort order unit.
// Depends on vfkso_pkg, vfkso_ctrl and vfkso_dp (which holds vfkso_ram).
//
//   channel   direction  signals                                      transfer when
//   input     in         in_valid_i, in_stall_o, entry_active_i/key   valid high, stall low
//   output    out        out_valid_o, out_stall_i, sorted_*/last_*    valid high, stall low
//
// Each input transfer loads one entry. The transfer that loads the last entry starts a
// sort over a record RAM: each bubble pass streams the RAM through one read port, with
// at most ENTRIES - 1 passes and an exit after the first pass without a swap. Emission
// then reads each result and loads it into the output register. Reset clears only
// control state; the RAM needs no clearing since every sort follows a full load. A
// stalled output only delays emission.
`default_nettype none

module valid_first_key_sort_order_unit import vfkso_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Entry input channel.
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 entry_active_i,
  input  wire logic [IN_KEY_W-1:0]  entry_key_i,
  // Sorted index output channel.
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [OUT_IDX_W-1:0] sorted_index_o,
  output logic                      sorted_active_o,
  output logic                      last_of_run_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences load, sort passes and emission; it only accepts
  // entries while in its load state.
  vfkso_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath keeps {rank, index} records in a RAM, so the permutation and the
  // keys move together and one read per step is enough to bubble a pass.
  vfkso_dp #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .entry_active_i  (entry_active_i),
    .entry_key_i     (entry_key_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sorted_index_o  (sorted_index_o),
    .sorted_active_o (sorted_active_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/vfkso_ram.sv
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
`default_nettype none

module vfkso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/vfkso_ctrl.sv
// Controller state machine for the sort order unit: load, sort passes, emit.
// Depends on vfkso_pkg for the state type and the command/status structs.
`default_nettype none

module vfkso_ctrl import vfkso_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_wr = 1'b1;
          if (sts_i.cnt_last) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        cmd_o.pass_start = 1'b1;
        state_d          = ST_PRIME;
      end
      ST_PRIME: begin
        cmd_o.prime = 1'b1;
        state_d     = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.run = 1'b1;
        if (sts_i.last_cmp) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d    = sts_i.more_passes ? ST_PRIME : ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_wr = 1'b1;
          state_d       = sts_i.cnt_last ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/vfkso_dp.sv
// Datapath of the sort order unit: record RAM, pass counters, carried record, output register.
// Depends on vfkso_pkg, vfkso_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vfkso_dp import vfkso_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  input  wire logic                 entry_active_i,
  input  wire logic [IN_KEY_W-1:0]  entry_key_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [OUT_IDX_W-1:0] sorted_index_o,
  output logic                      sorted_active_o,
  output logic                      last_of_run_o
);

  localparam int IdxW  = $clog2(ENTRIES);
  localparam int SkeyW = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;
  // Rank is {inactive, key or zero}; a record is {rank, load index}.
  localparam int RankW = SkeyW + 1;
  localparam int RecW  = RankW + IdxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);
  localparam logic [IdxW-1:0] OneIdx  = IdxW'(1);

  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] lim_q, lim_d;
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [IdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic            swapped_q, swapped_d;
  logic [RecW-1:0] carry_q, carry_d;
  logic            out_valid_q, out_valid_d;
  logic [OUT_IDX_W-1:0] out_idx_q;
  logic            out_act_q;
  logic            out_last_q;

  logic            we;
  logic [IdxW-1:0] waddr;
  logic [RecW-1:0] wdata;
  logic            re;
  logic [IdxW-1:0] raddr;
  logic [RecW-1:0] rdata;

  logic [RecW-1:0]      load_rec;
  logic [IdxW-1:0]      lim_m1;
  logic                 last_cmp;
  logic                 more_passes;
  logic                 do_swap;
  logic                 out_free;
  logic [OUT_IDX_W-1:0] rd_idx;

  vfkso_ram #(
    .WIDTH (RecW),
    .DEPTH (ENTRIES)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign load_rec = {~entry_active_i,
                     entry_active_i ? entry_key_i[SkeyW-1:0] : {SkeyW{1'b0}},
                     cnt_q};

  assign lim_m1      = lim_q - 1'b1;
  assign last_cmp    = (wr_ptr_q == lim_m1);
  assign more_passes = swapped_q && (lim_q != OneIdx);
  // Swap only on a strictly greater rank, which keeps the order stable.
  assign do_swap     = (carry_q[RecW-1 -: RankW] > rdata[RecW-1 -: RankW]);
  assign out_free    = !out_valid_q || !out_stall_i;

  generate
    if (IdxW >= OUT_IDX_W) begin : g_idx_trunc
      assign rd_idx = rdata[OUT_IDX_W-1:0];
    end else begin : g_idx_ext
      assign rd_idx = {{(OUT_IDX_W - IdxW){1'b0}}, rdata[IdxW-1:0]};
    end
  endgenerate

  // RAM ports.
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = load_rec;
    if (cmd_i.load_wr) begin
      we = 1'b1;
    end else if (cmd_i.run) begin
      we    = 1'b1;
      waddr = wr_ptr_q;
      wdata = do_swap ? rdata : carry_q;
    end else if (cmd_i.tail) begin
      we    = 1'b1;
      waddr = lim_q;
      wdata = carry_q;
    end

    re    = 1'b0;
    raddr = rd_ptr_q;
    if (cmd_i.pass_start || (cmd_i.tail && more_passes)) begin
      re    = 1'b1;
      raddr = '0;
    end else if (cmd_i.prime) begin
      re = 1'b1;
    end else if (cmd_i.run) begin
      re = !last_cmp;
    end else if (cmd_i.emit_rd) begin
      re    = 1'b1;
      raddr = cnt_q;
    end
  end

  // Counters and pass state.
  always_comb begin
    cnt_d     = cnt_q;
    lim_d     = lim_q;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    swapped_d = swapped_q;
    carry_d   = carry_q;

    if (cmd_i.load_wr || cmd_i.emit_wr) begin
      cnt_d = (cnt_q == LastIdx) ? '0 : cnt_q + 1'b1;
    end
    if (cmd_i.pass_start) begin
      lim_d    = LastIdx;
      rd_ptr_d = OneIdx;
    end
    if (cmd_i.tail && more_passes) begin
      lim_d    = lim_m1;
      rd_ptr_d = OneIdx;
    end
    if (cmd_i.prime) begin
      carry_d   = rdata;
      rd_ptr_d  = rd_ptr_q + 1'b1;
      wr_ptr_d  = '0;
      swapped_d = 1'b0;
    end
    if (cmd_i.run) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
      wr_ptr_d = wr_ptr_q + 1'b1;
      if (do_swap) begin
        swapped_d = 1'b1;
      end else begin
        carry_d = rdata;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit_wr) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      lim_q       <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      swapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      lim_q       <= lim_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      swapped_q   <= swapped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (cmd_i.emit_wr) begin
      out_idx_q  <= rd_idx;
      out_act_q  <= ~rdata[RecW-1];
      out_last_q <= (cnt_q == LastIdx);
    end
  end

  assign sts_o.cnt_last    = (cnt_q == LastIdx);
  assign sts_o.last_cmp    = last_cmp;
  assign sts_o.more_passes = more_passes;
  assign sts_o.out_free    = out_free;

  assign out_valid_o     = out_valid_q;
  assign sorted_index_o  = out_idx_q;
  assign sorted_active_o = out_act_q;
  assign last_of_run_o   = out_last_q;

  `VFK_ASSERT(a_emit_into_free, cmd_i.emit_wr |-> out_free, "emit into a held output")
  `VFK_ASSERT(a_run_in_bound, cmd_i.run |-> (wr_ptr_q < lim_q), "pass step beyond limit")
  `VFK_ASSERT(a_pass_shrinks, (cmd_i.tail && more_passes) |=> (lim_q == $past(lim_m1)),
              "pass limit did not shrink by one")
  `VFK_NEVER(a_one_cmd, (cmd_i.load_wr || cmd_i.emit_wr) && (cmd_i.run || cmd_i.tail),
             "load or emit during a sort pass")

endmodule

`default_nettype wire
